@@ rtl/jaad_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the joystick axis average/deadzone block.
// No dependencies; every rtl file imports this package.
package jaad_pkg;

  // defaults for the top-level parameters
  localparam int DEF_AVG_DEPTH   = 8;
  localparam int DEF_AXES        = 6;
  localparam int DEF_SAMPLE_BITS = 12;

  // fixed field widths
  localparam int MAX_AXES  = 6;
  localparam int IN_W      = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int VAL_W     = 16;
  localparam int IDX_W     = 3;
  localparam int QUO_W     = 16;

  localparam int SCALE_MUL = 32767;

  localparam logic [VAL_W-1:0] VAL_MAX = 16'h7FFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 16'h8000;

  // register reset values
  localparam logic [CFG_W-1:0] RST_CENTER     = 12'd2048;
  localparam logic [CFG_W-1:0] RST_DEADZONE   = 12'd64;
  localparam logic [CFG_W-1:0] RST_FULL_SCALE = 12'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER     = 2'd0,
    REG_DEADZONE   = 2'd1,
    REG_FULL_SCALE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] center;
    logic [CFG_W-1:0] deadzone;
    logic [CFG_W-1:0] full_scale;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] den;
    logic [CFG_W-1:0] rem_init;
    logic [QUO_W-1:0] num_low;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_AVG,
    BK_OFS,
    BK_CHK,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

@@ rtl/joystick_axis_average_deadzone.sv @@
`timescale 1ns / 1ps
// Joystick axis moving average with deadzone and 16-bit scaling.
// Each axis result is saturated directly or taken from the shared radix-2 divider.
// The front can take a new scan before the back end has finished the last one,
//   until the queue is full; each scan yields six axis words.
// Reset: registers to defaults, totals to depth*2048, ring reads as 2048 until
//   the write slot has wrapped once (fill flag, no clearing pass).
module joystick_axis_average_deadzone #(
  parameter int AVG_DEPTH   = jaad_pkg::DEF_AVG_DEPTH,
  parameter int AXES        = jaad_pkg::DEF_AXES,
  parameter int SAMPLE_BITS = jaad_pkg::DEF_SAMPLE_BITS
) (
  input  logic clk,
  input  logic rst_n,
  // scan input, one word per ADC scan
  input  logic in_valid,
  output logic in_ready,
  input  logic [jaad_pkg::IN_W-1:0] in_sample_left_x,
  input  logic [jaad_pkg::IN_W-1:0] in_sample_left_y,
  input  logic [jaad_pkg::IN_W-1:0] in_sample_left_z,
  input  logic [jaad_pkg::IN_W-1:0] in_sample_right_x,
  input  logic [jaad_pkg::IN_W-1:0] in_sample_right_y,
  input  logic [jaad_pkg::IN_W-1:0] in_sample_right_z,
  // one result word per axis
  output logic out_valid,
  input  logic out_ready,
  output logic [jaad_pkg::IDX_W-1:0] out_axis_index,
  output logic signed [jaad_pkg::VAL_W-1:0] out_axis_value,
  output logic out_last_axis,
  // register writes
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [jaad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jaad_pkg::CFG_W-1:0] cfg_data
);
  import jaad_pkg::*;

  localparam int TW    = SAMPLE_BITS + $clog2(AVG_DEPTH);
  localparam int ROW_W = AXES * TW;

  cfg_t cfg_r;
  logic [MAX_AXES-1:0][IN_W-1:0] samples;

  logic fifo_push, fifo_pop, fifo_full, fifo_empty;
  logic [ROW_W-1:0] push_data, pop_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // registers are always writable; writes are only expected while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center     <= RST_CENTER;
      cfg_r.deadzone   <= RST_DEADZONE;
      cfg_r.full_scale <= RST_FULL_SCALE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER:     cfg_r.center     <= cfg_data;
        REG_DEADZONE:   cfg_r.deadzone   <= cfg_data;
        REG_FULL_SCALE: cfg_r.full_scale <= cfg_data;
        default:        ; // unused index, write dropped
      endcase
    end
  end

  assign samples[0] = in_sample_left_x;
  assign samples[1] = in_sample_left_y;
  assign samples[2] = in_sample_left_z;
  assign samples[3] = in_sample_right_x;
  assign samples[4] = in_sample_right_y;
  assign samples[5] = in_sample_right_z;

  // front: ring update and running totals
  jaad_front #(
    .AVG_DEPTH  (AVG_DEPTH),
    .AXES       (AXES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_samples(samples),
    .fifo_full (fifo_full),
    .push      (fifo_push),
    .push_data (push_data)
  );

  // decouples ring update from the slow per-axis scaling
  jaad_fifo #(
    .WIDTH(ROW_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(push_data),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_data (pop_data),
    .empty    (fifo_empty)
  );

  // back: average, deadzone, scale, saturate, one axis at a time
  jaad_back #(
    .AVG_DEPTH  (AVG_DEPTH),
    .AXES       (AXES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .pop_empty     (fifo_empty),
    .pop           (fifo_pop),
    .pop_data      (pop_data),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_axis_index(out_axis_index),
    .out_axis_value(out_axis_value),
    .out_last_axis (out_last_axis)
  );

  jaad_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

endmodule

@@ rtl/jaad_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts a scan word, updates the sample ring and running totals,
// and pushes the totals of all axes into the queue. Depends on jaad_pkg.
module jaad_front #(
  parameter int AVG_DEPTH   = 8,
  parameter int AXES        = 6,
  parameter int SAMPLE_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [jaad_pkg::MAX_AXES-1:0][jaad_pkg::IN_W-1:0] in_samples,
  input  logic fifo_full,
  output logic push,
  output logic [AXES*(SAMPLE_BITS+$clog2(AVG_DEPTH))-1:0] push_data
);
  import jaad_pkg::*;

  localparam int TW     = SAMPLE_BITS + $clog2(AVG_DEPTH);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int ROW_W  = AXES * SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] FILL = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [TW-1:0] TOTAL_RST = TW'(AVG_DEPTH * (1 << (SAMPLE_BITS - 1)));
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);

  front_state_t state_r, state_nxt;
  logic accept;

  logic [AXES-1:0][SAMPLE_BITS-1:0] smp_in;
  logic [AXES-1:0][SAMPLE_BITS-1:0] smp_r;
  logic [AXES-1:0][SAMPLE_BITS-1:0] old_row;
  logic [ROW_W-1:0] hist_mem [AVG_DEPTH];
  logic [ROW_W-1:0] rd_row_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic filled_r, filled_nxt;
  logic [AXES-1:0][TW-1:0] total_r, total_nxt;

  assign in_ready = (state_r == FR_IDLE) && !fifo_full;
  assign accept   = in_valid && in_ready;

  // keep only the low SAMPLE_BITS of each raw sample
  always_comb begin
    logic [15:0] ext;
    for (int a = 0; a < AXES; a++) begin
      ext = {4'd0, in_samples[a]};
      smp_in[a] = ext[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE:   if (accept) state_nxt = FR_UPDATE;
      FR_UPDATE: state_nxt = FR_IDLE;
      default:   state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FR_IDLE;
    else        state_r <= state_nxt;
  end

  // ring row: read at accept, overwrite on the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= hist_mem[slot_r];
      smp_r    <= smp_in;
    end
    if (state_r == FR_UPDATE) hist_mem[slot_r] <= smp_r;
  end

  // a slot holds the reset fill until the write pointer has wrapped once
  assign old_row = filled_r ? rd_row_r : {AXES{FILL}};

  always_comb begin
    for (int a = 0; a < AXES; a++)
      total_nxt[a] = total_r[a] - TW'(old_row[a]) + TW'(smp_r[a]);
  end

  always_comb begin
    slot_nxt   = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
    filled_nxt = filled_r || (slot_r == SLOT_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      filled_r <= 1'b0;
      total_r  <= {AXES{TOTAL_RST}};
    end else if (state_r == FR_UPDATE) begin
      slot_r   <= slot_nxt;
      filled_r <= filled_nxt;
      total_r  <= total_nxt;
    end
  end

  assign push      = (state_r == FR_UPDATE);
  assign push_data = total_nxt;

  a_accept_updates: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == FR_UPDATE))
    else $error("front: accepted word not followed by update");

endmodule

@@ rtl/jaad_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry queue carrying per-scan running totals from front to back end.
// Depends on jaad_pkg only through the common import convention.
module jaad_fifo #(
  parameter int WIDTH = 90
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [WIDTH-1:0] push_data,
  output logic full,
  input  logic pop,
  output logic [WIDTH-1:0] pop_data,
  output logic empty
);
  import jaad_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("fifo: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("fifo: pop while empty");

endmodule

@@ rtl/jaad_div.sv @@
`timescale 1ns / 1ps
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on jaad_pkg (div_req_t, div_rsp_t).
module jaad_div (
  input  logic clk,
  input  logic rst_n,
  input  jaad_pkg::div_req_t req,
  output jaad_pkg::div_rsp_t rsp
);
  import jaad_pkg::*;

  localparam logic [3:0] CNT_LAST = 4'(QUO_W - 1);

  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] den_r;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [3:0] cnt_r;
  logic busy_r, done_r;
  logic [CFG_W:0] trial, diff;
  logic ge;

  // remainder stays below the divisor, so the shifted trial fits CFG_W+1 bits
  always_comb begin
    trial   = {rem_r, q_r[QUO_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
    q_nxt   = {q_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      q_r   <= req.num_low;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("div: start while busy");

endmodule

@@ rtl/jaad_back.sv @@
`timescale 1ns / 1ps
// Back end: per axis average, center offset, deadzone, scale and saturate,
// then the result register. Depends on jaad_pkg and the shared jaad_div.
module jaad_back #(
  parameter int AVG_DEPTH   = 8,
  parameter int AXES        = 6,
  parameter int SAMPLE_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  jaad_pkg::cfg_t cfg,
  input  logic pop_empty,
  output logic pop,
  input  logic [AXES*(SAMPLE_BITS+$clog2(AVG_DEPTH))-1:0] pop_data,
  output jaad_pkg::div_req_t div_req,
  input  jaad_pkg::div_rsp_t div_rsp,
  output logic out_valid,
  input  logic out_ready,
  output logic [jaad_pkg::IDX_W-1:0] out_axis_index,
  output logic signed [jaad_pkg::VAL_W-1:0] out_axis_value,
  output logic out_last_axis
);
  import jaad_pkg::*;

  localparam int TW   = SAMPLE_BITS + $clog2(AVG_DEPTH);
  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int MW   = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int NW   = MW + 15;
  localparam int CW   = NW + 1;
  localparam logic [TW:0] RECIP   = (TW + 1)'((1 << TW) / AVG_DEPTH);
  localparam logic [TW:0] DEPTH_C = (TW + 1)'(AVG_DEPTH);
  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);
  localparam logic [NW-1:0] SCALE_C = NW'(SCALE_MUL);

  back_state_t state_r, state_nxt;

  logic [AXES-1:0][TW-1:0] row_r;
  logic [AX_W-1:0] axis_r;
  logic [2*TW:0] prod_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic [NW-1:0] n_r;
  logic neg_r;
  logic [VAL_W-1:0] res_r;

  logic out_valid_r, out_last_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [VAL_W-1:0] out_val_r;

  logic [TW-1:0] tot_sel;
  logic [TW:0] q0, qd, rr, avg_fix;
  logic signed [MW:0] ofs;
  logic [MW-1:0] mag, mag_dz;
  logic [CFG_W-1:0] den;
  logic [CW-1:0] lim;
  logic sat;
  logic out_load;

  assign tot_sel = row_r[axis_r];

  // floor(total / depth): reciprocal product is at most one low, fix it up
  always_comb begin
    q0      = prod_r[2*TW:TW];
    qd      = (TW + 1)'(q0 * DEPTH_C);
    rr      = {1'b0, tot_sel} - qd;
    avg_fix = (rr >= DEPTH_C) ? q0 + 1'b1 : q0;
  end

  always_comb begin
    ofs    = $signed({1'b0, MW'(avg_r)}) - $signed({1'b0, MW'(cfg.center)});
    mag    = ofs[MW] ? MW'(-ofs) : ofs[MW-1:0];
    mag_dz = (mag < MW'(cfg.deadzone)) ? '0 : mag;
  end

  // signed result overflows 16 bits exactly when n >= den*32768 (+den if negative)
  always_comb begin
    den = (cfg.full_scale == '0) ? CFG_W'(1) : cfg.full_scale;
    lim = (CW'(den) << 15) + (neg_r ? CW'(den) : '0);
    sat = ({1'b0, n_r} >= lim);
  end

  assign out_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt        = state_r;
    pop              = 1'b0;
    div_req.start    = 1'b0;
    div_req.den      = den;
    div_req.rem_init = CFG_W'(n_r >> QUO_W);
    div_req.num_low  = n_r[QUO_W-1:0];
    unique case (state_r)
      BK_IDLE: begin
        if (!pop_empty) begin
          pop       = 1'b1;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: state_nxt = BK_AVG;
      BK_AVG: state_nxt = BK_OFS;
      BK_OFS: state_nxt = BK_CHK;
      BK_CHK: begin
        if (sat) begin
          state_nxt = BK_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = BK_DIV;
        end
      end
      BK_DIV: if (div_rsp.done) state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_load) state_nxt = (axis_r == AX_LAST) ? BK_IDLE : BK_MUL;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath registers, one step per state
  always_ff @(posedge clk) begin
    if (pop)                row_r  <= pop_data;
    if (state_r == BK_MUL)  prod_r <= (2 * TW + 1)'(tot_sel * RECIP);
    if (state_r == BK_AVG)  avg_r  <= SAMPLE_BITS'(avg_fix);
    if (state_r == BK_OFS) begin
      n_r   <= NW'(mag_dz) * SCALE_C;
      neg_r <= ofs[MW];
    end
    if (state_r == BK_CHK && sat) res_r <= neg_r ? VAL_MIN : VAL_MAX;
    if (state_r == BK_DIV && div_rsp.done)
      res_r <= neg_r ? VAL_W'(-div_rsp.quo) : div_rsp.quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
    end else if (pop) begin
      axis_r <= '0;
    end else if (state_r == BK_OUT && out_load && axis_r != AX_LAST) begin
      axis_r <= axis_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == BK_OUT && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_OUT && out_load) begin
      out_idx_r  <= IDX_W'(axis_r);
      out_val_r  <= res_r;
      out_last_r <= (axis_r == AX_LAST);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_axis_index = out_idx_r;
  assign out_axis_value = out_val_r;
  assign out_last_axis  = out_last_r;

  a_last_on_final_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_idx_r == IDX_W'(AXES - 1)))
    else $error("back: last flag on wrong axis");

  a_div_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("back: waiting on idle divider");

endmodule

@@ tb/axis_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for joystick_axis_average_deadzone: watches the scan, result
// and register ports, predicts each axis word and compares. Needs jaad_pkg.
module axis_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [jaad_pkg::IN_W-1:0]         in_sample_left_x,
  input  logic [jaad_pkg::IN_W-1:0]         in_sample_left_y,
  input  logic [jaad_pkg::IN_W-1:0]         in_sample_left_z,
  input  logic [jaad_pkg::IN_W-1:0]         in_sample_right_x,
  input  logic [jaad_pkg::IN_W-1:0]         in_sample_right_y,
  input  logic [jaad_pkg::IN_W-1:0]         in_sample_right_z,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [jaad_pkg::IDX_W-1:0]        out_axis_index,
  input  logic signed [jaad_pkg::VAL_W-1:0] out_axis_value,
  input  logic                              out_last_axis,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [jaad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jaad_pkg::CFG_W-1:0]        cfg_data,
  output int                                errors,
  output int                                pending
);
  import jaad_pkg::*;

  localparam int DEPTH  = DEF_AVG_DEPTH;
  localparam int AXES_N = DEF_AXES;
  localparam int TOT_W  = 15;
  localparam logic [IN_W-1:0] RING_FILL = IN_W'(1 << (DEF_SAMPLE_BITS - 1));

  typedef struct packed {
    logic [IDX_W-1:0]        axis;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } axis_word_t;

  axis_word_t       awaited_words[$];
  logic [CFG_W-1:0] center_q, dead_q, full_q;
  logic [IN_W-1:0]  ring [MAX_AXES][DEPTH];
  logic [TOT_W-1:0] total_q [MAX_AXES];
  int unsigned      slot_q;
  logic [IN_W-1:0]  smp [MAX_AXES];
  int               err_count = 0;

  assign smp[0] = in_sample_left_x;
  assign smp[1] = in_sample_left_y;
  assign smp[2] = in_sample_left_z;
  assign smp[3] = in_sample_right_x;
  assign smp[4] = in_sample_right_y;
  assign smp[5] = in_sample_right_z;
  assign errors = err_count;

  task automatic report(input string msg);
    $display("%0t ns: mismatch, %s", $time, msg);
    err_count++;
  endtask

  // floor average, less center, deadzone, scale toward zero, saturate
  function automatic logic signed [VAL_W-1:0] scaled_position(input logic [TOT_W-1:0] total);
    longint ofs, mag, den, v;
    ofs = longint'(total / DEPTH) - longint'(center_q);
    mag = (ofs < 0) ? -ofs : ofs;
    if (mag < longint'(dead_q)) ofs = 0;
    den = (full_q == '0) ? 1 : longint'(full_q);
    v = (ofs * SCALE_MUL) / den;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[VAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    axis_word_t w;
    int a;
    if (!rst_n) begin
      center_q = RST_CENTER;
      dead_q   = RST_DEADZONE;
      full_q   = RST_FULL_SCALE;
      for (a = 0; a < AXES_N; a++) begin
        for (int k = 0; k < DEPTH; k++) ring[a][k] = RING_FILL;
        total_q[a] = TOT_W'(DEPTH * RING_FILL);
      end
      slot_q = 0;
      awaited_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER:     center_q = cfg_data;
          REG_DEADZONE:   dead_q   = cfg_data;
          REG_FULL_SCALE: full_q   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          report($sformatf("unexpected word axis %0d value %0d", out_axis_index,
                           out_axis_value));
        end else begin
          w = awaited_words.pop_front();
          if (out_axis_index !== w.axis)
            report($sformatf("axis_index got %0d want %0d", out_axis_index, w.axis));
          if (out_axis_value !== w.value)
            report($sformatf("axis %0d value got %0d want %0d", w.axis,
                             out_axis_value, w.value));
          if (out_last_axis !== w.last)
            report($sformatf("axis %0d last_axis got %0b want %0b", w.axis,
                             out_last_axis, w.last));
        end
      end
      if (in_valid && in_ready) begin
        for (a = 0; a < AXES_N; a++) begin
          total_q[a] = total_q[a] - ring[a][slot_q] + smp[a];
          ring[a][slot_q] = smp[a];
        end
        slot_q = (slot_q == DEPTH - 1) ? 0 : slot_q + 1;
        for (a = 0; a < AXES_N; a++) begin
          w.axis  = a[IDX_W-1:0];
          w.value = scaled_position(total_q[a]);
          w.last  = (a == AXES_N - 1);
          awaited_words.push_back(w);
        end
      end
    end
    pending <= awaited_words.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the joystick_axis_average_deadzone bench: clock, reset, scan and
// register stimulus, receiver stalls and the verdict. Needs jaad_pkg,
// axis_result_checker and the rtl.
module tb;
  import jaad_pkg::*;

  localparam int AXES_N       = DEF_AXES;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RX_HOLD      = 600;   // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES  = 64;    // idle wait after draining, before the verdict
  // index 3 is not a register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] in_sample_left_x = '0;
  logic [IN_W-1:0] in_sample_left_y = '0;
  logic [IN_W-1:0] in_sample_left_z = '0;
  logic [IN_W-1:0] in_sample_right_x = '0;
  logic [IN_W-1:0] in_sample_right_y = '0;
  logic [IN_W-1:0] in_sample_right_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_axis_index;
  logic signed [VAL_W-1:0] out_axis_value;
  logic out_last_axis;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors;
  int pending;

  // scan under construction, and the center the random samples cluster around
  logic [IN_W-1:0] scan_buf [MAX_AXES];
  logic [CFG_W-1:0] cur_center = RST_CENTER;
  int burst_left = 0;
  bit rx_hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  joystick_axis_average_deadzone dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_left_x(in_sample_left_x), .in_sample_left_y(in_sample_left_y),
    .in_sample_left_z(in_sample_left_z), .in_sample_right_x(in_sample_right_x),
    .in_sample_right_y(in_sample_right_y), .in_sample_right_z(in_sample_right_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_axis_index(out_axis_index), .out_axis_value(out_axis_value),
    .out_last_axis(out_last_axis),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  axis_result_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_left_x(in_sample_left_x), .in_sample_left_y(in_sample_left_y),
    .in_sample_left_z(in_sample_left_z), .in_sample_right_x(in_sample_right_x),
    .in_sample_right_y(in_sample_right_y), .in_sample_right_z(in_sample_right_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_axis_index(out_axis_index), .out_axis_value(out_axis_value),
    .out_last_axis(out_last_axis),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Idle length for either side: mostly a few cycles, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // Joystick-like sample: full range, near the current center (deadzone
  // edges), or pinned at either rail.
  function automatic logic [IN_W-1:0] random_sample();
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom_range(0, 4095);
      3, 4:    v = int'(cur_center) + $urandom_range(0, 400) - 200;
      5:       v = 0;
      6:       v = 4095;
      default: v = int'(cur_center) + $urandom_range(0, 40) - 20;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[IN_W-1:0];
  endfunction

  // Offer scan_buf as one word and hold it until the block takes it.
  // in_valid stays high on return so a back-to-back word needs no drop.
  task automatic send_scan();
    @(negedge clk);
    in_valid          <= 1'b1;
    in_sample_left_x  <= scan_buf[0];
    in_sample_left_y  <= scan_buf[1];
    in_sample_left_z  <= scan_buf[2];
    in_sample_right_x <= scan_buf[3];
    in_sample_right_y <= scan_buf[4];
    in_sample_right_z <= scan_buf[5];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_rest(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Between words: runs of back-to-back words, otherwise gaps half the time.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(10, 30);
    end else if ($urandom_range(0, 1) == 0) begin
      sender_rest(pick_gap());
    end
  endtask

  // Every item yields six words, so an empty expectation store means the
  // block has nothing left in flight.
  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] center, input logic [CFG_W-1:0] dead,
                            input logic [CFG_W-1:0] full);
    sender_rest(1);
    wait_drained();
    write_reg(REG_CENTER, center);
    write_reg(REG_DEADZONE, dead);
    write_reg(REG_FULL_SCALE, full);
    cur_center = center;
  endtask

  // Random scans. Each axis keeps its last sample half the time, so the
  // averages settle and reach the rails and deadzone edges.
  task automatic run_scans(input int count, input bit with_pressure);
    int n, a;
    for (n = 0; n < count; n++) begin
      for (a = 0; a < AXES_N; a++)
        if ($urandom_range(0, 1) == 0) scan_buf[a] = random_sample();
      // receiver goes quiet while we keep offering: block fills, in_ready drops
      if (with_pressure && n == 40) rx_hold_req = 1'b1;
      // and once the sender stops until every word has come back
      if (with_pressure && n == 90) begin
        sender_rest(1);
        wait_drained();
      end
      send_scan();
      pace_sender();
    end
  endtask

  // Receiver: random stalls with quiet stretches, plus the long hold-off on
  // request, counted here.
  initial begin : rx_side
    int quiet_left;
    quiet_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        quiet_left = $urandom_range(20, 100);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int p;
    for (p = 0; p < MAX_AXES; p++) scan_buf[p] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers, ring still mostly at its reset fill: rails,
    // alternating bit patterns, near-center values.
    scan_buf = '{12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd2048, 12'd2111};
    send_scan();
    pace_sender();
    scan_buf = '{12'd4095, 12'd0, 12'h555, 12'hAAA, 12'd1985, 12'd2047};
    send_scan();
    pace_sender();
    scan_buf = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
    send_scan();
    pace_sender();

    // Center moved before the write slot wraps: the unwritten ring entries
    // must still hold the reset fill, not the new center.
    set_config(12'd1000, RST_DEADZONE, RST_FULL_SCALE);
    scan_buf = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
    send_scan();
    pace_sender();
    scan_buf = '{12'd1000, 12'd1063, 12'd937, 12'd1064, 12'd936, 12'd4095};
    send_scan();
    pace_sender();

    // Steady scans so every average is exact: full negative (saturates),
    // full positive, one inside each deadzone edge, one on each edge.
    set_config(RST_CENTER, RST_DEADZONE, RST_FULL_SCALE);
    scan_buf = '{12'd0, 12'd4095, 12'd2111, 12'd1985, 12'd2112, 12'd1984};
    repeat (8) begin
      send_scan();
      pace_sender();
    end

    run_scans(120, 1'b1);

    // smallest center, no deadzone, unit full scale: nearly all saturate
    set_config(12'd0, 12'd0, 12'd1);
    run_scans(60, 1'b0);

    // largest everything: deadzone swallows all but a full-negative average
    set_config(12'hFFF, 12'hFFF, 12'hFFF);
    run_scans(40, 1'b0);

    // zero full scale is treated as one; write to the unused index is a no-op
    set_config(RST_CENTER, 12'd0, 12'd0);
    write_reg(REG_UNUSED, 12'hFFF);
    run_scans(60, 1'b0);

    repeat (3) begin
      set_config(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 300)),
                 CFG_W'($urandom_range(1, 4095)));
      run_scans(60, 1'b0);
    end

    sender_rest(1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

@@ joystick_axis_average_deadzone.f @@
rtl/jaad_pkg.sv
rtl/jaad_front.sv
rtl/jaad_fifo.sv
rtl/jaad_div.sv
rtl/jaad_back.sv
rtl/joystick_axis_average_deadzone.sv
tb/axis_result_checker.sv
tb/tb.sv
